/* rtl/priority_input_queued_switch_top_assert.svh */
// assertion macros used by the switch checker
`ifndef PRIORITY_INPUT_QUEUED_SWITCH_TOP_ASSERT_SVH
`define PRIORITY_INPUT_QUEUED_SWITCH_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define PIQS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("switch check failed");

// next-cycle implication, sampled on clk, off during reset
`define PIQS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("switch check failed");

`endif

/* rtl/piqs_pkg.sv */
// ----------------------------------------------------------------------------
// piqs_pkg
// Shared codes, entry layout and helpers of the priority input-queued switch.
// ----------------------------------------------------------------------------
package piqs_pkg;

    localparam logic [1:0] FUNC_ARRIVAL = 2'd0;
    localparam logic [1:0] FUNC_SWITCH  = 2'd1;
    localparam logic [1:0] FUNC_POP     = 2'd2;

    localparam logic [2:0] ST_QUEUED    = 3'd0;
    localparam logic [2:0] ST_IN_DROP   = 3'd1;
    localparam logic [2:0] ST_MOVED     = 3'd2;
    localparam logic [2:0] ST_OUT_DROP  = 3'd3;
    localparam logic [2:0] ST_NOTHING   = 3'd4;
    localparam logic [2:0] ST_POPPED    = 3'd5;
    localparam logic [2:0] ST_OUT_EMPTY = 3'd6;

    localparam logic [9:0] WINC_RESET = 10'd50;

    typedef struct packed {
        logic [15:0] id;
        logic [2:0]  prio;
        logic [7:0]  serv;
        logic [15:0] wait_time;
    } out_entry_t;

    function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

endpackage

/* rtl/priority_input_queued_switch_top.sv */
// ----------------------------------------------------------------------------
// priority_input_queued_switch_top
// Input-queued packet switch with strict-priority service and output FIFOs.
//
//   channel | direction | handshake           | contents
//   in      | in        | in_valid / in_stall | func, port, dest_port, ...
//   out     | out       | out_valid/out_stall | status, packet_id, totals
//   cfg     | in        | cfg_valid/cfg_ready | wait_increment
//
// arrivals, pops of an empty queue, switch slots with nothing waiting and the
// unused code finish in S_EXEC; other pops add S_POP_RD and other switch slots
// S_SW_RD for the queue memory read, plus S_SW_HEAD when the served queue
// keeps packets and its new head priority must be fetched.
// queue memories need no clearing, so items are taken straight after reset.
// a stalled output holds the block in its result step until the transfer.
// ----------------------------------------------------------------------------
module priority_input_queued_switch_top #(
    parameter int INPUT_PORTS  = 8,
    parameter int OUTPUT_PORTS = 8,
    parameter int QUEUE_DEPTH  = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  func,
    input  logic [2:0]  port,
    input  logic [2:0]  dest_port,
    input  logic [2:0]  priority_req,
    input  logic [7:0]  arrival_service,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic [15:0] packet_id,
    output logic [2:0]  from_port,
    output logic [2:0]  to_port,
    output logic [2:0]  packet_priority,
    output logic [7:0]  packet_service,
    output logic [15:0] packet_wait,
    output logic [31:0] total_waiting,
    output logic [31:0] total_turnaround,
    output logic [31:0] total_dropped,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [9:0]  cfg_data
);

    import piqs_pkg::*;

    localparam int IW   = $clog2(INPUT_PORTS);
    localparam int OW   = $clog2(OUTPUT_PORTS);
    localparam int DW   = $clog2(QUEUE_DEPTH);
    localparam int CW   = $clog2(QUEUE_DEPTH + 1);
    localparam int TW   = CW + 1;
    localparam int SW   = $clog2(1024 * QUEUE_DEPTH);
    localparam int AWI  = $clog2(INPUT_PORTS * QUEUE_DEPTH);
    localparam int AWO  = $clog2(OUTPUT_PORTS * QUEUE_DEPTH);

    // stamp is the queue's wait sum at arrival; waiting = sum now - stamp
    typedef struct packed {
        logic [15:0]   id;
        logic [2:0]    dest;
        logic [2:0]    prio;
        logic [7:0]    serv;
        logic [SW-1:0] stamp;
    } in_entry_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SW_RD,
        S_SW_HEAD,
        S_POP_RD
    } state_t;

    state_t state_reg;

    logic [1:0]  func_reg;
    logic [2:0]  port_reg;
    logic [2:0]  dest_reg;
    logic [2:0]  prio_reg;
    logic [7:0]  serv_reg;
    logic [IW-1:0] best_reg;

    logic [DW-1:0] in_head_reg  [INPUT_PORTS];
    logic [CW-1:0] in_count_reg [INPUT_PORTS];
    logic [SW-1:0] in_sum_reg   [INPUT_PORTS];
    logic [2:0]    head_prio_reg [INPUT_PORTS];
    logic [DW-1:0] out_head_reg  [OUTPUT_PORTS];
    logic [CW-1:0] out_count_reg [OUTPUT_PORTS];

    logic [15:0] acc_reg;
    logic [9:0]  winc_reg;
    logic [31:0] wsum_reg, wsum_next;
    logic [31:0] tsum_reg, tsum_next;
    logic [31:0] dsum_reg, dsum_next;

    logic        out_valid_reg;
    logic [2:0]  status_reg;
    logic [15:0] id_reg;
    logic [2:0]  from_reg;
    logic [2:0]  to_reg;
    logic [2:0]  pr_reg;
    logic [7:0]  sv_reg;
    logic [15:0] wt_reg;
    logic [31:0] tw_reg, tt_reg, td_reg;

    // memory ports
    logic            in_we, in_re;
    logic [AWI-1:0]  in_waddr, in_raddr;
    in_entry_t       in_wdata, in_rd;
    logic [$bits(in_entry_t)-1:0] in_rdata_raw;
    logic            out_we, out_re;
    logic [AWO-1:0]  out_waddr, out_raddr;
    out_entry_t      out_wdata, out_rd;
    logic [$bits(out_entry_t)-1:0] out_rdata_raw;

    // result
    logic        res_fire;
    logic [2:0]  res_status;
    logic [15:0] res_id;
    logic [2:0]  res_from, res_to, res_pr;
    logic [7:0]  res_sv;
    logic [15:0] res_wt;

    logic [INPUT_PORTS-1:0] nonempty;
    logic                   arb_found;
    logic [IW-1:0]          arb_best;

    logic          out_free;
    logic          ip_ok, ip_full;
    logic [IW-1:0] ip_idx;
    logic          op_ok;
    logic [OW-1:0] op_idx;
    logic [15:0]   new_id;
    logic [SW-1:0] sw_diff;
    logic [15:0]   sw_wait;
    logic          od_ok;
    logic [OW-1:0] od_idx;
    logic [CW-1:0] sw_left;
    logic [DW-1:0] sw_next_head;

    function automatic logic [DW-1:0] wrap_add(input logic [DW-1:0] h, input logic [CW-1:0] c);
        logic [TW-1:0] t;
        t = TW'(h) + TW'(c);
        if (t >= TW'(QUEUE_DEPTH))
        begin
            t = t - TW'(QUEUE_DEPTH);
        end
        return t[DW-1:0];
    endfunction

    function automatic logic [AWI-1:0] in_addr(input logic [IW-1:0] q, input logic [DW-1:0] s);
        return AWI'(q) * AWI'(QUEUE_DEPTH) + AWI'(s);
    endfunction

    function automatic logic [AWO-1:0] out_addr(input logic [OW-1:0] q, input logic [DW-1:0] s);
        return AWO'(q) * AWO'(QUEUE_DEPTH) + AWO'(s);
    endfunction

    assign in_rd  = in_rdata_raw;
    assign out_rd = out_rdata_raw;

    piqs_ram #(
        .WIDTH ($bits(in_entry_t)),
        .DEPTH (INPUT_PORTS * QUEUE_DEPTH)
    ) u_in_ram (
        .clk   (clk),
        .we    (in_we),
        .waddr (in_waddr),
        .wdata (in_wdata),
        .re    (in_re),
        .raddr (in_raddr),
        .rdata (in_rdata_raw)
    );

    piqs_ram #(
        .WIDTH ($bits(out_entry_t)),
        .DEPTH (OUTPUT_PORTS * QUEUE_DEPTH)
    ) u_out_ram (
        .clk   (clk),
        .we    (out_we),
        .waddr (out_waddr),
        .wdata (out_wdata),
        .re    (out_re),
        .raddr (out_raddr),
        .rdata (out_rdata_raw)
    );

    always_comb
    begin
        for (int i = 0; i < INPUT_PORTS; i++)
        begin
            nonempty[i] = (in_count_reg[i] != '0);
        end
    end

    piqs_arbiter #(
        .INPUT_PORTS (INPUT_PORTS)
    ) u_arbiter (
        .nonempty  (nonempty),
        .head_prio (head_prio_reg),
        .found     (arb_found),
        .best      (arb_best)
    );

    always_comb
    begin
        out_free = !out_valid_reg || !out_stall;

        ip_ok   = (32'(port_reg) < INPUT_PORTS);
        ip_idx  = IW'(port_reg);
        ip_full = (in_count_reg[ip_idx] == CW'(QUEUE_DEPTH));
        op_idx  = OW'(port_reg);
        op_ok   = (32'(port_reg) < OUTPUT_PORTS) && (out_count_reg[op_idx] != '0);
        new_id  = acc_reg + 16'd1;

        sw_diff = in_sum_reg[best_reg] - in_rd.stamp;
        if ((SW + 16)'(sw_diff) > (SW + 16)'(16'hFFFF))
        begin
            sw_wait = 16'hFFFF;
        end
        else
        begin
            sw_wait = 16'(sw_diff);
        end
        od_idx       = OW'(in_rd.dest);
        od_ok        = (32'(in_rd.dest) < OUTPUT_PORTS)
                       && (out_count_reg[od_idx] != CW'(QUEUE_DEPTH));
        sw_left      = in_count_reg[best_reg] - CW'(1);
        sw_next_head = wrap_add(in_head_reg[best_reg], CW'(1));

        in_we      = 1'b0;
        in_waddr   = '0;
        in_wdata   = '0;
        in_re      = 1'b0;
        in_raddr   = '0;
        out_we     = 1'b0;
        out_waddr  = '0;
        out_wdata  = '0;
        out_re     = 1'b0;
        out_raddr  = '0;
        res_fire   = 1'b0;
        res_status = ST_NOTHING;
        res_id     = '0;
        res_from   = '0;
        res_to     = '0;
        res_pr     = '0;
        res_sv     = '0;
        res_wt     = '0;
        wsum_next  = wsum_reg;
        tsum_next  = tsum_reg;
        dsum_next  = dsum_reg;

        case (state_reg)
            S_EXEC:
            begin
                case (func_reg)
                    FUNC_ARRIVAL:
                    begin
                        if (out_free)
                        begin
                            res_fire = 1'b1;
                            res_id   = new_id;
                            res_from = port_reg;
                            res_to   = dest_reg;
                            res_pr   = prio_reg;
                            res_sv   = serv_reg;
                            if (ip_ok && !ip_full)
                            begin
                                in_we          = 1'b1;
                                in_waddr       = in_addr(ip_idx,
                                    wrap_add(in_head_reg[ip_idx], in_count_reg[ip_idx]));
                                in_wdata.id    = new_id;
                                in_wdata.dest  = dest_reg;
                                in_wdata.prio  = prio_reg;
                                in_wdata.serv  = serv_reg;
                                in_wdata.stamp = in_sum_reg[ip_idx];
                                res_status     = ST_QUEUED;
                            end
                            else
                            begin
                                dsum_next  = sat_add32(dsum_reg, 32'd1);
                                res_status = ST_IN_DROP;
                            end
                        end
                    end
                    FUNC_SWITCH:
                    begin
                        if (arb_found)
                        begin
                            in_re    = 1'b1;
                            in_raddr = in_addr(arb_best, in_head_reg[arb_best]);
                        end
                        else if (out_free)
                        begin
                            res_fire = 1'b1;
                        end
                    end
                    FUNC_POP:
                    begin
                        if (op_ok)
                        begin
                            out_re    = 1'b1;
                            out_raddr = out_addr(op_idx, out_head_reg[op_idx]);
                        end
                        else if (out_free)
                        begin
                            res_fire   = 1'b1;
                            res_status = ST_OUT_EMPTY;
                            res_to     = port_reg;
                        end
                    end
                    default:
                    begin
                        res_fire = out_free;
                    end
                endcase
            end
            S_SW_RD:
            begin
                if (out_free)
                begin
                    res_fire = 1'b1;
                    res_id   = in_rd.id;
                    res_from = 3'(best_reg);
                    res_to   = in_rd.dest;
                    res_pr   = in_rd.prio;
                    res_sv   = in_rd.serv;
                    res_wt   = sw_wait;
                    if (od_ok)
                    begin
                        out_we              = 1'b1;
                        out_waddr           = out_addr(od_idx,
                            wrap_add(out_head_reg[od_idx], out_count_reg[od_idx]));
                        out_wdata.id        = in_rd.id;
                        out_wdata.prio      = in_rd.prio;
                        out_wdata.serv      = in_rd.serv;
                        out_wdata.wait_time = sw_wait;
                        wsum_next  = sat_add32(wsum_reg, 32'(sw_wait));
                        tsum_next  = sat_add32(tsum_reg, 32'(sw_wait) + 32'(in_rd.serv));
                        res_status = ST_MOVED;
                    end
                    else
                    begin
                        dsum_next  = sat_add32(dsum_reg, 32'd1);
                        res_status = ST_OUT_DROP;
                    end
                    // fetch the new head so its priority is ready for arbitration
                    if (sw_left != '0)
                    begin
                        in_re    = 1'b1;
                        in_raddr = in_addr(best_reg, sw_next_head);
                    end
                end
            end
            S_POP_RD:
            begin
                if (out_free)
                begin
                    res_fire   = 1'b1;
                    res_status = ST_POPPED;
                    res_id     = out_rd.id;
                    res_to     = port_reg;
                    res_pr     = out_rd.prio;
                    res_sv     = out_rd.serv;
                    res_wt     = out_rd.wait_time;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            acc_reg       <= '0;
            winc_reg      <= WINC_RESET;
            wsum_reg      <= '0;
            tsum_reg      <= '0;
            dsum_reg      <= '0;
            best_reg      <= '0;
            for (int i = 0; i < INPUT_PORTS; i++)
            begin
                in_head_reg[i]   <= '0;
                in_count_reg[i]  <= '0;
                in_sum_reg[i]    <= '0;
                head_prio_reg[i] <= '0;
            end
            for (int i = 0; i < OUTPUT_PORTS; i++)
            begin
                out_head_reg[i]  <= '0;
                out_count_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_valid)
            begin
                winc_reg <= cfg_data;
            end

            wsum_reg <= wsum_next;
            tsum_reg <= tsum_next;
            dsum_reg <= dsum_next;

            if (res_fire)
            begin
                out_valid_reg <= 1'b1;
                status_reg    <= res_status;
                id_reg        <= res_id;
                from_reg      <= res_from;
                to_reg        <= res_to;
                pr_reg        <= res_pr;
                sv_reg        <= res_sv;
                wt_reg        <= res_wt;
                tw_reg        <= wsum_next;
                tt_reg        <= tsum_next;
                td_reg        <= dsum_next;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        func_reg  <= func;
                        port_reg  <= port;
                        dest_reg  <= dest_port;
                        prio_reg  <= priority_req;
                        serv_reg  <= arrival_service;
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    case (func_reg)
                        FUNC_ARRIVAL:
                        begin
                            if (out_free)
                            begin
                                if (ip_ok && !ip_full)
                                begin
                                    in_count_reg[ip_idx] <= in_count_reg[ip_idx] + CW'(1);
                                    acc_reg <= new_id;
                                    if (in_count_reg[ip_idx] == '0)
                                    begin
                                        head_prio_reg[ip_idx] <= prio_reg;
                                    end
                                end
                                state_reg <= S_IDLE;
                            end
                        end
                        FUNC_SWITCH:
                        begin
                            if (arb_found)
                            begin
                                best_reg  <= arb_best;
                                state_reg <= S_SW_RD;
                            end
                            else if (out_free)
                            begin
                                state_reg <= S_IDLE;
                            end
                        end
                        FUNC_POP:
                        begin
                            if (op_ok)
                            begin
                                state_reg <= S_POP_RD;
                            end
                            else if (out_free)
                            begin
                                state_reg <= S_IDLE;
                            end
                        end
                        default:
                        begin
                            if (out_free)
                            begin
                                state_reg <= S_IDLE;
                            end
                        end
                    endcase
                end
                S_SW_RD:
                begin
                    if (out_free)
                    begin
                        in_head_reg[best_reg]  <= sw_next_head;
                        in_count_reg[best_reg] <= sw_left;
                        in_sum_reg[best_reg]   <= in_sum_reg[best_reg] + SW'(winc_reg);
                        if (od_ok)
                        begin
                            out_count_reg[od_idx] <= out_count_reg[od_idx] + CW'(1);
                        end
                        state_reg <= (sw_left != '0) ? S_SW_HEAD : S_IDLE;
                    end
                end
                S_SW_HEAD:
                begin
                    head_prio_reg[best_reg] <= in_rd.prio;
                    state_reg               <= S_IDLE;
                end
                S_POP_RD:
                begin
                    if (out_free)
                    begin
                        out_head_reg[op_idx]  <= wrap_add(out_head_reg[op_idx], CW'(1));
                        out_count_reg[op_idx] <= out_count_reg[op_idx] - CW'(1);
                        state_reg             <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_stall         = (state_reg != S_IDLE);
    assign cfg_ready        = 1'b1;
    assign out_valid        = out_valid_reg;
    assign status           = status_reg;
    assign packet_id        = id_reg;
    assign from_port        = from_reg;
    assign to_port          = to_reg;
    assign packet_priority  = pr_reg;
    assign packet_service   = sv_reg;
    assign packet_wait      = wt_reg;
    assign total_waiting    = tw_reg;
    assign total_turnaround = tt_reg;
    assign total_dropped    = td_reg;

endmodule

/* rtl/piqs_ram.sv */
// ----------------------------------------------------------------------------
// piqs_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module piqs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* rtl/piqs_arbiter.sv */
// ----------------------------------------------------------------------------
// piqs_arbiter
// Strict-priority pick over the input queue heads, ties to the lowest port.
// ----------------------------------------------------------------------------
module piqs_arbiter #(
    parameter int INPUT_PORTS = 8
) (
    input  logic [INPUT_PORTS-1:0]         nonempty,
    input  logic [2:0]                     head_prio [INPUT_PORTS],
    output logic                           found,
    output logic [$clog2(INPUT_PORTS)-1:0] best
);

    localparam int IW = $clog2(INPUT_PORTS);

    logic [2:0] best_prio;

    always_comb
    begin
        found     = 1'b0;
        best      = '0;
        best_prio = '0;
        for (int i = 0; i < INPUT_PORTS; i++)
        begin
            if (nonempty[i] && (!found || head_prio[i] > best_prio))
            begin
                found     = 1'b1;
                best      = IW'(i);
                best_prio = head_prio[i];
            end
        end
    end

endmodule

/* rtl/piqs_checker.sv */
// ----------------------------------------------------------------------------
// piqs_checker
// Port-level checks of the switch, bound to the top level.
// ----------------------------------------------------------------------------
`include "priority_input_queued_switch_top_assert.svh"

module piqs_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [2:0]  status,
    input logic [15:0] packet_id,
    input logic [2:0]  to_port,
    input logic [15:0] packet_wait
);

    import piqs_pkg::*;

    // a pending result is not withdrawn
    `PIQS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)

    // one item at a time: busy right after an input transfer
    `PIQS_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

    // idle slot or stray code carries no packet
    `PIQS_ASSERT_NOW(a_nothing_empty, out_valid && status == ST_NOTHING,
        packet_id == 16'd0 && packet_wait == 16'd0 && to_port == 3'd0)

    // input drops and fresh arrivals have not waited
    `PIQS_ASSERT_NOW(a_arrival_no_wait,
        out_valid && (status == ST_QUEUED || status == ST_IN_DROP),
        packet_wait == 16'd0)

endmodule

bind priority_input_queued_switch_top piqs_checker u_piqs_checker (.*);

/* verif/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the priority input-queued switch. A behavioural
// model of the input and output FIFOs predicts every result; a checker
// compares each output transfer field by field, in order, under random
// idling on both channels and several wait increment settings.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import piqs_pkg::*;

    localparam int NPORTS = 8;
    localparam int DEPTH  = 64;
    localparam int CYCLE_LIMIT = 600000;

    typedef struct packed {
        logic [2:0]  st;
        logic [15:0] id;
        logic [2:0]  from;
        logic [2:0]  to;
        logic [2:0]  prio;
        logic [7:0]  serv;
        logic [15:0] wt;
        logic [31:0] tot_wait;
        logic [31:0] tot_turn;
        logic [31:0] tot_drop;
    } switch_result_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  func;
    logic [2:0]  port;
    logic [2:0]  dest_port;
    logic [2:0]  priority_req;
    logic [7:0]  arrival_service;
    logic        out_valid;
    logic        out_stall;
    logic [2:0]  status;
    logic [15:0] packet_id;
    logic [2:0]  from_port;
    logic [2:0]  to_port;
    logic [2:0]  packet_priority;
    logic [7:0]  packet_service;
    logic [15:0] packet_wait;
    logic [31:0] total_waiting;
    logic [31:0] total_turnaround;
    logic [31:0] total_dropped;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [9:0]  cfg_data;

    // switch model state
    logic [15:0] iq_id   [NPORTS][DEPTH];
    logic [2:0]  iq_dest [NPORTS][DEPTH];
    logic [2:0]  iq_prio [NPORTS][DEPTH];
    logic [7:0]  iq_serv [NPORTS][DEPTH];
    logic [15:0] iq_wait [NPORTS][DEPTH];
    int          iq_head [NPORTS];
    int          iq_count[NPORTS];
    logic [15:0] oq_id   [NPORTS][DEPTH];
    logic [2:0]  oq_prio [NPORTS][DEPTH];
    logic [7:0]  oq_serv [NPORTS][DEPTH];
    logic [15:0] oq_wait [NPORTS][DEPTH];
    int          oq_head [NPORTS];
    int          oq_count[NPORTS];
    logic [15:0] last_id;
    logic [31:0] sum_wait;
    logic [31:0] sum_turn;
    logic [31:0] sum_drop;
    logic [9:0]  model_winc;

    switch_result_t pending_results[$];
    int  status_seen[8] = '{default: 0};
    int  error_count = 0;
    int  items_sent;
    int  results_checked = 0;
    int  cycles = 0;
    bit  quiet;

    priority_input_queued_switch_top u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .func(func), .port(port), .dest_port(dest_port),
        .priority_req(priority_req), .arrival_service(arrival_service),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .packet_id(packet_id), .from_port(from_port),
        .to_port(to_port), .packet_priority(packet_priority),
        .packet_service(packet_service), .packet_wait(packet_wait),
        .total_waiting(total_waiting), .total_turnaround(total_turnaround),
        .total_dropped(total_dropped),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    function automatic logic [31:0] add_sat32(logic [31:0] a, logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic void model_reset();
        for (int i = 0; i < NPORTS; i++)
        begin
            iq_head[i] = 0; iq_count[i] = 0;
            oq_head[i] = 0; oq_count[i] = 0;
        end
        last_id = '0; sum_wait = '0; sum_turn = '0; sum_drop = '0;
        model_winc = WINC_RESET;
    endfunction

    // works out the result of one accepted item and updates the switch model
    function automatic void predict_switch(logic [1:0] f, logic [2:0] p, logic [2:0] d,
                                           logic [2:0] pr, logic [7:0] sv);
        switch_result_t r;
        bit found;
        int best;
        int slot;
        logic [2:0] bprio;
        logic [16:0] w;
        r = '0;
        r.st = ST_NOTHING;
        found = 0; best = 0; bprio = '0;
        if (f == FUNC_ARRIVAL)
        begin
            r.id = last_id + 16'd1;
            r.from = p; r.to = d; r.prio = pr; r.serv = sv;
            if (iq_count[p] < DEPTH)
            begin
                slot = (iq_head[p] + iq_count[p]) % DEPTH;
                iq_id[p][slot] = r.id; iq_dest[p][slot] = d; iq_prio[p][slot] = pr;
                iq_serv[p][slot] = sv; iq_wait[p][slot] = '0;
                iq_count[p]++;
                last_id = r.id;
                r.st = ST_QUEUED;
            end
            else
            begin
                sum_drop = add_sat32(sum_drop, 32'd1);
                r.st = ST_IN_DROP;
            end
        end
        else if (f == FUNC_SWITCH)
        begin
            for (int i = 0; i < NPORTS; i++)
                if (iq_count[i] != 0 && (!found || iq_prio[i][iq_head[i]] > bprio))
                begin
                    found = 1; best = i; bprio = iq_prio[i][iq_head[i]];
                end
            if (found)
            begin
                slot = iq_head[best];
                r.id = iq_id[best][slot]; r.from = best[2:0]; r.to = iq_dest[best][slot];
                r.prio = iq_prio[best][slot]; r.serv = iq_serv[best][slot];
                r.wt = iq_wait[best][slot];
                iq_head[best] = (iq_head[best] + 1) % DEPTH;
                iq_count[best]--;
                // packets left behind in the served queue wait longer
                for (int k = 0; k < iq_count[best]; k++)
                begin
                    slot = (iq_head[best] + k) % DEPTH;
                    w = {1'b0, iq_wait[best][slot]} + {7'd0, model_winc};
                    iq_wait[best][slot] = w[16] ? 16'hFFFF : w[15:0];
                end
                if (oq_count[r.to] < DEPTH)
                begin
                    slot = (oq_head[r.to] + oq_count[r.to]) % DEPTH;
                    oq_id[r.to][slot] = r.id; oq_prio[r.to][slot] = r.prio;
                    oq_serv[r.to][slot] = r.serv; oq_wait[r.to][slot] = r.wt;
                    oq_count[r.to]++;
                    sum_wait = add_sat32(sum_wait, {16'd0, r.wt});
                    sum_turn = add_sat32(sum_turn, {16'd0, r.wt} + {24'd0, r.serv});
                    r.st = ST_MOVED;
                end
                else
                begin
                    sum_drop = add_sat32(sum_drop, 32'd1);
                    r.st = ST_OUT_DROP;
                end
            end
        end
        else if (f == FUNC_POP)
        begin
            r.to = p;
            if (oq_count[p] != 0)
            begin
                slot = oq_head[p];
                r.id = oq_id[p][slot]; r.prio = oq_prio[p][slot];
                r.serv = oq_serv[p][slot]; r.wt = oq_wait[p][slot];
                oq_head[p] = (oq_head[p] + 1) % DEPTH;
                oq_count[p]--;
                r.st = ST_POPPED;
            end
            else
                r.st = ST_OUT_EMPTY;
        end
        r.tot_wait = sum_wait; r.tot_turn = sum_turn; r.tot_drop = sum_drop;
        pending_results = {pending_results, r};
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    task automatic send_item(logic [1:0] f, logic [2:0] p, logic [2:0] d,
                             logic [2:0] pr, logic [7:0] sv);
        in_valid <= 1'b1;
        func <= f; port <= p; dest_port <= d; priority_req <= pr; arrival_service <= sv;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_switch(f, p, d, pr, sv);
        items_sent++;
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_wait_increment(logic [9:0] value);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        model_winc = value;
    endtask

    task automatic send_random_item();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 42)
            send_item(FUNC_ARRIVAL, 3'($urandom), 3'($urandom), 3'($urandom), 8'($urandom));
        else if (pick < 75)
            send_item(FUNC_SWITCH, 3'($urandom), 3'($urandom), 3'($urandom), 8'($urandom));
        else if (pick < 96)
            send_item(FUNC_POP, 3'($urandom), 3'($urandom), 3'($urandom), 8'($urandom));
        else
            send_item(2'd3, 3'($urandom), 3'($urandom), 3'($urandom), 8'($urandom));
    endtask

    // empty switch, field extremes, priority ties and the unused code
    task automatic test_directed();
        send_item(FUNC_SWITCH, 3'd0, 3'd0, 3'd0, 8'd0);
        send_item(FUNC_POP, 3'd7, 3'd0, 3'd0, 8'd0);
        send_item(2'd3, 3'd7, 3'd7, 3'd7, 8'hFF);
        send_item(FUNC_ARRIVAL, 3'd7, 3'd0, 3'd3, 8'hFF);
        send_item(FUNC_ARRIVAL, 3'd2, 3'd7, 3'd3, 8'd0);
        send_item(FUNC_ARRIVAL, 3'd2, 3'd5, 3'd7, 8'h80);
        send_item(FUNC_ARRIVAL, 3'd0, 3'd1, 3'd0, 8'd1);
        send_item(FUNC_ARRIVAL, 3'd5, 3'd7, 3'd7, 8'h7F);
        send_item(FUNC_SWITCH, 3'd0, 3'd0, 3'd0, 8'd0);
        send_item(FUNC_SWITCH, 3'd0, 3'd0, 3'd0, 8'd0);
        send_item(FUNC_SWITCH, 3'd0, 3'd0, 3'd0, 8'd0);
        send_item(FUNC_SWITCH, 3'd0, 3'd0, 3'd0, 8'd0);
        send_item(FUNC_SWITCH, 3'd0, 3'd0, 3'd0, 8'd0);
        send_item(FUNC_SWITCH, 3'd0, 3'd0, 3'd0, 8'd0);
        send_item(FUNC_POP, 3'd7, 3'd0, 3'd0, 8'd0);
        send_item(FUNC_POP, 3'd0, 3'd0, 3'd0, 8'd0);
        send_item(FUNC_POP, 3'd7, 3'd0, 3'd0, 8'd0);
        send_item(FUNC_POP, 3'd7, 3'd0, 3'd0, 8'd0);
        send_item(FUNC_POP, 3'd7, 3'd0, 3'd0, 8'd0);
    endtask

    // fill an input queue past full, then an output queue past full
    task automatic test_queue_full();
        for (int n = 0; n < DEPTH + 2; n++)
            send_item(FUNC_ARRIVAL, 3'd4, 3'd6, 3'($urandom), 8'($urandom));
        for (int n = 0; n < DEPTH; n++)
            send_item(FUNC_ARRIVAL, 3'd1, 3'd6, 3'($urandom), 8'($urandom));
        for (int n = 0; n < 2 * DEPTH + 1; n++)
            send_item(FUNC_SWITCH, 3'd0, 3'd0, 3'd0, 8'd0);
        for (int n = 0; n < DEPTH + 1; n++)
            send_item(FUNC_POP, 3'd6, 3'd0, 3'd0, 8'd0);
    endtask

    task automatic test_random_traffic(int count);
        for (int n = 0; n < count; n++)
            send_random_item();
    endtask

    // result checker
    always @(posedge clk)
    begin
        switch_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $display("unexpected result transfer at %0t", $realtime);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                results_checked++;
                status_seen[status]++;
                if (status != want.st)
                    report_mismatch("status", 32'(status), 32'(want.st));
                if (packet_id != want.id)
                    report_mismatch("packet_id", 32'(packet_id), 32'(want.id));
                if (from_port != want.from)
                    report_mismatch("from_port", 32'(from_port), 32'(want.from));
                if (to_port != want.to)
                    report_mismatch("to_port", 32'(to_port), 32'(want.to));
                if (packet_priority != want.prio)
                    report_mismatch("packet_priority", 32'(packet_priority), 32'(want.prio));
                if (packet_service != want.serv)
                    report_mismatch("packet_service", 32'(packet_service), 32'(want.serv));
                if (packet_wait != want.wt)
                    report_mismatch("packet_wait", 32'(packet_wait), 32'(want.wt));
                if (total_waiting != want.tot_wait)
                    report_mismatch("total_waiting", total_waiting, want.tot_wait);
                if (total_turnaround != want.tot_turn)
                    report_mismatch("total_turnaround", total_turnaround, want.tot_turn);
                if (total_dropped != want.tot_drop)
                    report_mismatch("total_dropped", total_dropped, want.tot_drop);
            end
        end
    end

    // receiver stalls in bursts
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (!quiet && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 13)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("tb_top: errors");
            $finish;
        end
    end

    initial
    begin
        clk = 1'b0; rst_n = 1'b0; in_valid = 1'b0; func = '0; port = '0;
        dest_port = '0; priority_req = '0; arrival_service = '0;
        cfg_valid = 1'b0; cfg_data = '0;
        items_sent = 0; quiet = 0;
        model_reset();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        write_wait_increment(10'd1023);
        test_queue_full();
        test_random_traffic(250);
        write_wait_increment(10'd0);
        test_random_traffic(250);
        write_wait_increment(10'($urandom_range(1, 1022)));
        test_random_traffic(250);
        write_wait_increment(10'd50);
        // sender holds off until the switch has answered everything
        drain();
        test_random_traffic(200);
        quiet = 1;
        test_random_traffic(150);
        drain();

        $display("%0d items sent, %0d results checked over four wait increment settings",
                 items_sent, results_checked);
        $display("status counts q%0d id%0d mv%0d od%0d nw%0d pp%0d oe%0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3],
                 status_seen[4], status_seen[5], status_seen[6]);
        if (error_count == 0 && pending_results.size() == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
